// File: design/xdzr_pkg.sv
package xdzr_pkg;

  // Frame store size and config register
  localparam int unsigned FRAME_CAPACITY_DEF = 4096;
  localparam int unsigned CFG_W              = 13;
  localparam logic [CFG_W-1:0] FRAME_BYTES_RST = 13'd4096;

  // Result index width, fixed by the output format
  localparam int unsigned IDX_W = 12;

  // Run count varint: 7 data bits per byte, group counter saturates at 7
  localparam int unsigned DIGIT_BITS = 7;
  localparam logic [2:0]  GROUP_MAX  = 3'd7;

  // Result queue depth (output register plus skid room for the RMW stage)
  localparam int unsigned OUTQ_DEPTH = 3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       raw_frame;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       new_value;
  } out_item_t;

  // Store update request from the decoder to the RMW stage
  typedef struct packed {
    logic       vld;
    logic [7:0] delta;
  } upd_op_t;

endpackage

// File: design/xor_delta_zero_run_decoder.sv
// Port group   Direction  Handshake            Payload
// in_*         input      in_valid / in_stall  in_item_t (byte, frame end, raw flag)
// out_*        output     out_valid/out_stall  out_item_t (index, new value)
// cfg_*        input      cfg_wr_en            frame_bytes, 13 bits
//
// One payload byte per cycle while in_stall is low. A changed byte passes the store
// read and the XOR in the modify stage, then is written into the result queue, from
// whose head it is offered on out_*.
// After reset a clearing pass zeroes every one of the FRAME_CAPACITY store entries
// (4096 by default); in_stall stays high during it.
// in_stall rises when the three-entry result queue plus the byte in the modify
// stage could overflow, so out_stall backs up into in_stall after that slack.
module xor_delta_zero_run_decoder import xdzr_pkg::*; #(
  parameter int unsigned FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam int unsigned AW = $clog2(FRAME_CAPACITY);

  logic          accept;
  upd_op_t       op;
  logic [AW-1:0] op_addr;
  logic          clr_busy;
  logic          res_vld;
  out_item_t     res;
  logic [1:0]    q_cnt;

  // Input flow control
  assign in_stall = clr_busy || ((3'(q_cnt) + 3'(res_vld)) >= 3'(OUTQ_DEPTH));
  assign accept   = in_valid && !in_stall;

  xdzr_ctrl #(
    .FRAME_CAPACITY (FRAME_CAPACITY),
    .AW             (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .item        (in_data),
    .op          (op),
    .op_addr     (op_addr)
  );

  xdzr_rmw #(
    .FRAME_CAPACITY (FRAME_CAPACITY),
    .AW             (AW)
  ) u_rmw (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .op_addr  (op_addr),
    .clr_busy (clr_busy),
    .res_vld  (res_vld),
    .res      (res)
  );

  xdzr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_cnt)
  );

endmodule

// File: design/xdzr_ctrl.sv
module xdzr_ctrl import xdzr_pkg::*; #(
  parameter int unsigned FRAME_CAPACITY = FRAME_CAPACITY_DEF,
  parameter int unsigned AW             = $clog2(FRAME_CAPACITY)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             accept,
  input  in_item_t         item,
  output upd_op_t          op,
  output logic [AW-1:0]    op_addr
);

  localparam int unsigned PW = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned CW = (PW > CFG_W) ? PW : CFG_W;
  localparam int unsigned SW = PW + DIGIT_BITS;
  localparam logic [PW-1:0] CAP = PW'(FRAME_CAPACITY);

  logic [CFG_W-1:0] frame_bytes_r;
  logic [PW-1:0]    wpos_r, wpos_nxt;
  logic             coll_r, coll_nxt;
  logic [PW-1:0]    run_r, run_nxt;
  logic [2:0]       grp_r, grp_nxt;

  logic [CW-1:0]    lim;
  logic             in_frame;
  logic [6:0]       shift;
  logic             part_big;
  logic [SW-1:0]    part;
  logic [SW:0]      run_sum;
  logic [PW-1:0]    run_new;
  logic [PW:0]      pos_sum;
  logic [7:0]       b;

  // Size in use and whether the write position is still inside it
  always_comb begin
    lim      = (CW'(frame_bytes_r) < CW'(CAP)) ? CW'(frame_bytes_r) : CW'(CAP);
    in_frame = CW'(wpos_r) < lim;
    b        = item.payload_byte;
  end

  // Varint group accumulate, saturating at capacity
  always_comb begin
    shift    = 7'(grp_r) * 7'(DIGIT_BITS);
    part_big = (b[6:0] != 7'd0) && (shift >= 7'(PW));
    part     = SW'(b[6:0]) << shift;
    run_sum  = (SW+1)'(run_r) + (SW+1)'(part);
    run_new  = (part_big || run_sum > (SW+1)'(CAP)) ? CAP : PW'(run_sum);
    pos_sum  = (PW+1)'(wpos_r) + (PW+1)'(run_new);
  end

  // Next decoder state and store update request
  always_comb begin
    wpos_nxt = wpos_r;
    coll_nxt = coll_r;
    run_nxt  = run_r;
    grp_nxt  = grp_r;
    op.vld   = 1'b0;
    op.delta = b;
    op_addr  = AW'(wpos_r);
    priority if (item.raw_frame || (!coll_r && b != 8'd0)) begin
      coll_nxt = 1'b0;
      if (in_frame) begin
        op.vld   = accept && (b != 8'd0);
        wpos_nxt = wpos_r + PW'(1);
      end
    end else if (!coll_r) begin
      // zero byte in a coded frame opens a run count
      coll_nxt = 1'b1;
      run_nxt  = '0;
      grp_nxt  = '0;
    end else begin
      run_nxt = run_new;
      grp_nxt = (grp_r < GROUP_MAX) ? grp_r + 3'd1 : grp_r;
      if (!b[7]) begin
        wpos_nxt = (pos_sum > (PW+1)'(CAP)) ? CAP : PW'(pos_sum);
        coll_nxt = 1'b0;
        run_nxt  = '0;
        grp_nxt  = '0;
      end
    end
    if (item.frame_end) begin
      wpos_nxt = '0;
      coll_nxt = 1'b0;
      run_nxt  = '0;
      grp_nxt  = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r <= FRAME_BYTES_RST;
      wpos_r        <= '0;
      coll_r        <= 1'b0;
      run_r         <= '0;
      grp_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        frame_bytes_r <= cfg_wr_data;
      end
      if (accept) begin
        wpos_r <= wpos_nxt;
        coll_r <= coll_nxt;
        run_r  <= run_nxt;
        grp_r  <= grp_nxt;
      end
    end
  end

endmodule

// File: design/xdzr_rmw.sv
module xdzr_rmw import xdzr_pkg::*; #(
  parameter int unsigned FRAME_CAPACITY = FRAME_CAPACITY_DEF,
  parameter int unsigned AW             = $clog2(FRAME_CAPACITY)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  upd_op_t       op,
  input  logic [AW-1:0] op_addr,
  output logic          clr_busy,
  output logic          res_vld,
  output out_item_t     res
);

  logic [7:0]    mem [FRAME_CAPACITY];
  logic [7:0]    rdata_r;

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  logic          s1_vld_r;
  logic [AW-1:0] s1_addr_r;
  logic [7:0]    s1_delta_r;

  logic          wr_vld_r;
  logic [AW-1:0] wr_addr_r;
  logic [7:0]    wr_data_r;

  logic [7:0]    cur;
  logic [7:0]    new_val;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // Forward the write of the previous cycle when it hit the same entry
  always_comb begin
    cur       = (wr_vld_r && wr_addr_r == s1_addr_r) ? wr_data_r : rdata_r;
    new_val   = cur ^ s1_delta_r;
    mem_we    = clr_busy_r || s1_vld_r;
    mem_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
    mem_wdata = clr_busy_r ? 8'd0 : new_val;
  end

  // Frame store: one read and one write port
  always_ff @(posedge clk) begin
    rdata_r <= mem[op_addr];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(FRAME_CAPACITY - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Modify stage and write tracking for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= op.vld;
      wr_vld_r <= s1_vld_r;
    end
    s1_addr_r  <= op_addr;
    s1_delta_r <= op.delta;
    wr_addr_r  <= s1_addr_r;
    wr_data_r  <= new_val;
  end

  assign clr_busy       = clr_busy_r;
  assign res_vld        = s1_vld_r;
  assign res.byte_index = IDX_W'(s1_addr_r);
  assign res.new_value  = new_val;

endmodule

// File: design/xdzr_outq.sv
module xdzr_outq import xdzr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  output logic [1:0] count
);

  localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);

  out_item_t         q_r [OUTQ_DEPTH];
  logic [PTR_W-1:0]  rd_ptr_r, wr_ptr_r;
  logic [1:0]        cnt_r;
  logic              pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign count     = cnt_r;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: bench/xdzr_change_checker.sv
// Watches the payload, result and frame_bytes ports of the decoder, keeps its
// own copy of the frame store and decoder state, and checks every result
// transaction against the oldest predicted store change.
module xdzr_change_checker import xdzr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  output int               fail_count,
  output int               changes_pending
);

  localparam int unsigned CAP = FRAME_CAPACITY_DEF;

  // Shadow of the frame store and the decoder position
  logic [7:0]       shadow [CAP];
  logic [CFG_W-1:0] frame_bytes;
  int unsigned      wr_pos;
  int unsigned      run_acc;
  bit               in_count;
  logic [2:0]       grp;

  // Store changes predicted but not yet seen at the output
  out_item_t changes_due[$];

  // Apply one payload byte to the shadow store
  task automatic decode_byte(input in_item_t it);
    int unsigned       lim;
    longint unsigned   sum;
    logic [7:0]        b;
    out_item_t         chg;
    begin
      b   = it.payload_byte;
      lim = (frame_bytes < CAP) ? int'(frame_bytes) : CAP;
      if (it.raw_frame || (!in_count && b != 8'h00)) begin
        // delta byte; a raw byte also drops an open run count
        in_count = 1'b0;
        if (wr_pos < lim) begin
          if (b != 8'h00) begin
            shadow[wr_pos] ^= b;
            chg.byte_index = IDX_W'(wr_pos);
            chg.new_value  = shadow[wr_pos];
            changes_due.push_back(chg);
          end
          wr_pos++;
        end
      end else if (!in_count) begin
        // zero byte in a coded frame opens a run count
        in_count = 1'b1;
        run_acc  = 0;
        grp      = '0;
      end else begin
        // next 7-bit group of the little-endian count, saturating
        sum = longint'(run_acc) + (longint'(b[6:0]) << (DIGIT_BITS * grp));
        run_acc = (sum > CAP) ? CAP : int'(sum);
        if (grp != GROUP_MAX) grp++;
        if (!b[7]) begin
          wr_pos   = (wr_pos + run_acc > CAP) ? CAP : wr_pos + run_acc;
          in_count = 1'b0;
          run_acc  = 0;
          grp      = '0;
        end
      end
      if (it.frame_end) begin
        wr_pos   = 0;
        in_count = 1'b0;
        run_acc  = 0;
        grp      = '0;
      end
    end
  endtask

  // Compare one result transaction with the oldest predicted change
  task automatic check_change(input out_item_t got);
    out_item_t want;
    begin
      if (changes_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected change: idx %0d val %02h", got.byte_index, got.new_value);
      end else begin
        want = changes_due.pop_front();
        if (got.byte_index !== want.byte_index || got.new_value !== want.new_value) begin
          fail_count++;
          if (fail_count <= 10)
            $display("change mismatch: want idx %0d val %02h, got idx %0d val %02h",
                     want.byte_index, want.new_value, got.byte_index, got.new_value);
        end
      end
    end
  endtask

  initial begin
    fail_count      = 0;
    changes_pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAP; i++) shadow[i] = 8'h00;
      frame_bytes = FRAME_BYTES_RST;
      wr_pos      = 0;
      run_acc     = 0;
      in_count    = 1'b0;
      grp         = '0;
      changes_due.delete();
    end else begin
      if (cfg_wr_en) frame_bytes = cfg_wr_data;
      if (in_valid && !in_stall) decode_byte(in_data);
      if (out_valid && !out_stall) check_change(out_data);
    end
    changes_pending = changes_due.size();
  end

endmodule

// File: bench/tb.sv
module tb;
  import xdzr_pkg::*;

  localparam int unsigned CAP         = FRAME_CAPACITY_DEF;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned LIMIT       = 300000;

  typedef enum {FLOW, SPARSE, PERIODIC, HEAVY} stall_mode_e;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;

  int          fail_count;
  int          changes_pending;
  int          burst_left;
  int          items_sent;
  int unsigned size_now;
  int unsigned cycle_count;
  bit          no_gaps;
  bit          hold_req;
  bit          hold_done;
  in_item_t    frame_q[$];

  xor_delta_zero_run_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  xdzr_change_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .changes_pending(changes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side: stall pattern picked at random for random stretches, plus one long hold
  initial begin
    stall_mode_e mode;
    int          left;
    out_stall = 1'b0;
    hold_done = 1'b0;
    mode      = FLOW;
    left      = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          FLOW:     out_stall = 1'b0;
          SPARSE:   out_stall = ($urandom_range(0, 2) == 0);
          PERIODIC: out_stall = ((left % 4) < 2);
          default:  out_stall = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one payload byte; entered and left at a falling edge
  task automatic put_byte(input logic [7:0] b, input logic last, input logic raw);
    int gap;
    begin
      if (burst_left == 0) begin
        if (!no_gaps) begin
          gap      = $urandom_range(1, 6);
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      in_valid = 1'b1;
      in_data  = '{payload_byte: b, frame_end: last, raw_frame: raw};
      do @(posedge clk); while (in_stall);
      items_sent++;
      @(negedge clk);
    end
  endtask

  // Wait until every predicted change has come out and the pipe is empty
  task automatic settle;
    begin
      in_valid = 1'b0;
      while (changes_pending != 0) @(negedge clk);
      repeat (8) @(negedge clk);
    end
  endtask

  task automatic write_frame_bytes(input logic [CFG_W-1:0] v);
    begin
      settle();
      cfg_wr_en   = 1'b1;
      cfg_wr_data = v;
      @(negedge clk);
      cfg_wr_en = 1'b0;
      size_now  = (v < CAP) ? int'(v) : CAP;
    end
  endtask

  function automatic in_item_t coded(input logic [7:0] b);
    return '{payload_byte: b, frame_end: 1'b0, raw_frame: 1'b0};
  endfunction

  // Zero byte followed by the varint count, with optional redundant groups
  task automatic push_run(input int unsigned count, input int pad);
    logic [6:0] digit;
    begin
      frame_q.push_back(coded(8'h00));
      forever begin
        digit = count[6:0];
        count = count >> 7;
        if (count == 0 && pad == 0) begin
          frame_q.push_back(coded({1'b0, digit}));
          break;
        end
        if (count == 0) pad--;
        frame_q.push_back(coded({1'b1, digit}));
      end
    end
  endtask

  task automatic send_frame;
    begin
      for (int i = 0; i < frame_q.size(); i++)
        put_byte(frame_q[i].payload_byte, i == frame_q.size() - 1, frame_q[i].raw_frame);
    end
  endtask

  // One random frame: mostly well formed, sometimes mangled
  task automatic random_frame;
    int       span;
    int       n;
    int       r;
    int       idx;
    in_item_t junk;
    begin
      span = (size_now + 3 < 40) ? size_now + 3 : 40;
      frame_q.delete();
      if ($urandom_range(0, 1)) begin
        n = $urandom_range(1, span);
        for (int i = 0; i < n; i++)
          frame_q.push_back('{payload_byte: ($urandom_range(0, 4) == 0) ? 8'h00
                                             : 8'($urandom_range(1, 255)),
                              frame_end: 1'b0, raw_frame: 1'b1});
      end else begin
        n = $urandom_range(1, (span > 16) ? 16 : span);
        for (int t = 0; t < n; t++) begin
          r = $urandom_range(0, 9);
          if (r < 6)
            frame_q.push_back(coded(8'($urandom_range(1, 255))));
          else if (r < 9)
            push_run($urandom_range(0, size_now + 2), ($urandom_range(0, 4) == 0));
          else
            push_run(($urandom_range(0, 1)) ? $urandom_range(0, 20000) : $urandom,
                     $urandom_range(0, 8));
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        idx = $urandom_range(0, frame_q.size() - 1);
        case ($urandom_range(0, 2))
          0: frame_q[idx].raw_frame = ~frame_q[idx].raw_frame;
          1: while (frame_q.size() > idx + 1) void'(frame_q.pop_back());
          default: begin
            junk = '{payload_byte: 8'($urandom), frame_end: 1'b0,
                     raw_frame: 1'($urandom)};
            frame_q.insert(idx, junk);
          end
        endcase
      end
      send_frame();
    end
  endtask

  task automatic run_phase(input int ph);
    int               target;
    logic [CFG_W-1:0] sz;
    begin
      case (ph)
        0:       sz = 13'd1;
        1:       sz = 13'd0;
        2:       sz = 13'h1FFF;
        5:       sz = CFG_W'($urandom_range(0, 8191));
        6:       sz = 13'd4096;
        default: sz = CFG_W'($urandom_range(2, 48));
      endcase
      write_frame_bytes(sz);
      target = items_sent + ((ph == 1) ? 20 : 45);
      // long result hold while the sender keeps offering back to back
      if (ph == 4) begin
        no_gaps  = 1'b1;
        hold_req = 1'b1;
      end
      while (items_sent < target) random_frame();
      if (ph == 4) begin
        in_valid = 1'b0;
        while (!hold_done) @(negedge clk);
        no_gaps = 1'b0;
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    no_gaps     = 1'b0;
    hold_req    = 1'b0;
    burst_left  = 0;
    items_sent  = 0;
    size_now    = CAP;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // raw frame with a zero delta inside
    put_byte(8'hFF, 1'b0, 1'b1);
    put_byte(8'h00, 1'b0, 1'b1);
    put_byte(8'h01, 1'b0, 1'b1);
    put_byte(8'h80, 1'b1, 1'b1);
    // coded frame: short run, then a two-group run
    put_byte(8'h55, 1'b0, 1'b0);
    put_byte(8'h00, 1'b0, 1'b0);
    put_byte(8'h03, 1'b0, 1'b0);
    put_byte(8'hAA, 1'b0, 1'b0);
    put_byte(8'h00, 1'b0, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b0);
    put_byte(8'h01, 1'b0, 1'b0);
    put_byte(8'h22, 1'b1, 1'b0);
    // raw byte arriving inside an open count
    put_byte(8'h00, 1'b0, 1'b0);
    put_byte(8'h85, 1'b0, 1'b0);
    put_byte(8'h33, 1'b1, 1'b1);
    // count left open at frame end, then a fresh frame
    put_byte(8'h00, 1'b1, 1'b0);
    put_byte(8'h44, 1'b1, 1'b0);
    // saturating count past the group limit, then bytes beyond the frame
    put_byte(8'h00, 1'b0, 1'b0);
    repeat (7) put_byte(8'hFF, 1'b0, 1'b0);
    put_byte(8'h7F, 1'b0, 1'b0);
    put_byte(8'h12, 1'b0, 1'b0);
    put_byte(8'h34, 1'b1, 1'b1);
    // frame size shrinks in the middle of a frame
    put_byte(8'h01, 1'b0, 1'b1);
    put_byte(8'h02, 1'b0, 1'b1);
    write_frame_bytes(13'd2);
    put_byte(8'h03, 1'b1, 1'b1);

    for (int ph = 0; ph < 8; ph++) run_phase(ph);
    settle();

    if (fail_count == 0 && changes_pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
